/* rtl/core/jts_pkg.sv */
// Shared types and constants for the job table scheduler.
// Used by jts_cell and job_table_scheduler; depends on nothing else.
package jts_pkg;

    // Table depth and the widths that follow from it
    localparam int MAX_JOBS = 16;
    localparam int POS_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);

    localparam int ID_W     = 8;
    localparam int LEN_W    = 16;
    localparam int SLICE_W  = 16;
    localparam int MODE_W   = 2;
    localparam int FUNC_W   = 2;

    // Scheduling modes (code 3 behaves as first come first served)
    localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SJF  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RR   = 2'd2;

    // Event kinds (code 3 is ignored)
    localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EXIT   = 2'd2;

    // Configuration register indexes
    localparam logic CFG_MODE        = 1'b0;
    localparam logic CFG_SLICE_LIMIT = 1'b1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [LEN_W-1:0]  job_length;
    } req_word_t;

    typedef struct packed {
        logic [ID_W-1:0]  current_id;
        logic [CNT_W-1:0] job_count;
        logic             switched;
        logic             halted;
        logic             rejected;
    } rsp_word_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    // Broadcast from the top level to every cell
    typedef struct packed {
        cell_op_t         op;
        logic             sjf;
        logic [ID_W-1:0]  new_id;
        logic [LEN_W-1:0] new_len;
        logic [CNT_W-1:0] count;
        logic [POS_W-1:0] run;
    } cell_ctrl_t;

endpackage

/* rtl/core/job_table_scheduler.sv */
// Job table scheduler: row of shifting cells plus run position and slice control.
// The result word is registered on the edge that accepts the item.
// Throughput: one item per cycle while results are taken; the whole row inserts or removes in a single shift,
// with the shortest-job insertion point rippling through the cells in the same cycle.
// Reset: control registers and counters cleared (mode 0, slice limit 4); the table
// contents and the result word are not cleared and need no clearing pass.
module job_table_scheduler (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  jts_pkg::req_word_t         req_word,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output jts_pkg::rsp_word_t         rsp_word,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [jts_pkg::SLICE_W-1:0] cfg_data
);

    localparam int N = jts_pkg::MAX_JOBS;

    // Configuration
    logic [jts_pkg::MODE_W-1:0]  mode_reg;
    logic [jts_pkg::SLICE_W-1:0] slice_limit_reg;

    // Scheduler state
    logic [jts_pkg::CNT_W-1:0]   count_reg,  count_next;
    logic [jts_pkg::POS_W-1:0]   run_reg,    run_next;
    logic [jts_pkg::SLICE_W-1:0] slice_reg,  slice_next;
    logic [jts_pkg::ID_W-1:0]    nid_reg,    nid_next;
    logic                        stop_reg,   stop_next;

    // Result stage
    logic                        rsp_valid_reg, rsp_valid_next;
    jts_pkg::rsp_word_t          rsp_word_reg,  rsp_word_next;

    logic                        accept;
    jts_pkg::cell_ctrl_t         ctrl;
    logic                        sw;
    logic                        rej;
    logic                        ins_hit;
    logic [jts_pkg::SLICE_W-1:0] slice_inc;
    logic [jts_pkg::CNT_W-1:0]   run_adv;
    logic [jts_pkg::CNT_W-1:0]   count_dec;

    // Cell row wiring
    logic [jts_pkg::ID_W-1:0]    cell_id      [N];
    logic [jts_pkg::LEN_W-1:0]   cell_len     [N];
    logic [jts_pkg::ID_W-1:0]    cell_id_next [N];
    logic [N-1:0]                cell_moving;
    logic [N-1:0]                cell_hit;
    logic [N:0]                  suffix;

    assign cfg_ready = 1'b1;
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    // The far right end of the row counts as longer than anything
    assign suffix[N] = 1'b1;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            logic [jts_pkg::ID_W-1:0]  l_id;
            logic [jts_pkg::LEN_W-1:0] l_len;
            logic                      l_moving;
            logic [jts_pkg::ID_W-1:0]  r_id;
            logic [jts_pkg::LEN_W-1:0] r_len;

            if (g == 0)
            begin : g_left_edge
                assign l_id     = '0;
                assign l_len    = '0;
                assign l_moving = 1'b0;
            end
            else
            begin : g_left
                assign l_id     = cell_id[g-1];
                assign l_len    = cell_len[g-1];
                assign l_moving = cell_moving[g-1];
            end

            if (g == N - 1)
            begin : g_right_edge
                assign r_id  = '0;
                assign r_len = '0;
            end
            else
            begin : g_right
                assign r_id  = cell_id[g+1];
                assign r_len = cell_len[g+1];
            end

            jts_cell #(
                .INDEX (g)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .left_id     (l_id),
                .left_len    (l_len),
                .left_moving (l_moving),
                .right_id    (r_id),
                .right_len   (r_len),
                .suffix_in   (suffix[g+1]),
                .suffix_out  (suffix[g]),
                .moving      (cell_moving[g]),
                .hit         (cell_hit[g]),
                .id          (cell_id[g]),
                .len         (cell_len[g]),
                .id_next     (cell_id_next[g])
            );
        end
    endgenerate

    // An insert lands at or before the running slot when that slot moves right
    assign ins_hit = |cell_hit;

    assign slice_inc = (slice_reg == {jts_pkg::SLICE_W{1'b1}}) ?
                       slice_reg : slice_reg + jts_pkg::SLICE_W'(1);
    assign run_adv   = jts_pkg::CNT_W'(run_reg) + jts_pkg::CNT_W'(1);
    assign count_dec = count_reg - jts_pkg::CNT_W'(1);

    always_comb
    begin
        count_next = count_reg;
        run_next   = run_reg;
        slice_next = slice_reg;
        nid_next   = nid_reg;
        stop_next  = stop_reg;
        sw         = 1'b0;
        rej        = 1'b0;

        ctrl.op      = jts_pkg::CELL_HOLD;
        ctrl.sjf     = 1'b0;
        ctrl.new_id  = nid_reg;
        ctrl.new_len = req_word.job_length;
        ctrl.count   = count_reg;
        ctrl.run     = run_reg;

        if (accept && !stop_reg)
        begin
            priority if (req_word.func == jts_pkg::FUNC_CREATE)
            begin
                if (count_reg >= jts_pkg::CNT_W'(N))
                begin
                    rej = 1'b1;
                end
                else
                begin
                    ctrl.op    = jts_pkg::CELL_INSERT;
                    ctrl.sjf   = (mode_reg == jts_pkg::MODE_SJF);
                    nid_next   = nid_reg + jts_pkg::ID_W'(1);
                    count_next = count_reg + jts_pkg::CNT_W'(1);
                    sw         = (count_reg == '0) || ins_hit;
                end
            end
            else if (req_word.func == jts_pkg::FUNC_TICK)
            begin
                if ((mode_reg == jts_pkg::MODE_RR) && (count_reg != '0))
                begin
                    slice_next = slice_inc;
                    if (slice_inc > slice_limit_reg)
                    begin
                        // Preempt: advance to the next slot, wrapping at the end
                        if (run_adv >= count_reg)
                        begin
                            run_next = '0;
                        end
                        else
                        begin
                            run_next = run_adv[jts_pkg::POS_W-1:0];
                        end
                        sw         = (run_next != run_reg);
                        slice_next = '0;
                    end
                end
            end
            else if (req_word.func == jts_pkg::FUNC_EXIT)
            begin
                if (count_reg != '0)
                begin
                    ctrl.op    = jts_pkg::CELL_REMOVE;
                    count_next = count_dec;
                    sw         = 1'b1;
                    if (count_dec == '0)
                    begin
                        stop_next = 1'b1;
                        run_next  = '0;
                    end
                    else if (jts_pkg::CNT_W'(run_reg) >= count_dec)
                    begin
                        run_next = '0;
                    end
                end
            end
            else
            begin
                // Unused event code: report the state
                sw = 1'b0;
            end
        end
    end

    // Build the result word from the state after this item
    always_comb
    begin
        rsp_word_next.switched = sw;
        rsp_word_next.rejected = rej;
        rsp_word_next.halted   = stop_next;
        if (stop_next)
        begin
            rsp_word_next.current_id = '0;
            rsp_word_next.job_count  = '0;
        end
        else
        begin
            rsp_word_next.job_count  = count_next;
            rsp_word_next.current_id = (count_next != '0) ? cell_id_next[run_next] : '0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= jts_pkg::MODE_FCFS;
            slice_limit_reg <= jts_pkg::SLICE_W'(4);
            count_reg       <= '0;
            run_reg         <= '0;
            slice_reg       <= '0;
            nid_reg         <= '0;
            stop_reg        <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    jts_pkg::CFG_MODE:        mode_reg        <= cfg_data[jts_pkg::MODE_W-1:0];
                    jts_pkg::CFG_SLICE_LIMIT: slice_limit_reg <= cfg_data;
                    default:                  mode_reg        <= mode_reg;
                endcase
            end
            count_reg     <= count_next;
            run_reg       <= run_next;
            slice_reg     <= slice_next;
            nid_reg       <= nid_next;
            stop_reg      <= stop_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

/* rtl/core/jts_cell.sv */
// One slot of the job table: holds an id and a length, shifts left or right.
// Depends on jts_pkg.
module jts_cell #(
    parameter int INDEX = 0
) (
    input  logic                      clk,
    input  jts_pkg::cell_ctrl_t       ctrl,
    input  logic [jts_pkg::ID_W-1:0]  left_id,
    input  logic [jts_pkg::LEN_W-1:0] left_len,
    input  logic                      left_moving,
    input  logic [jts_pkg::ID_W-1:0]  right_id,
    input  logic [jts_pkg::LEN_W-1:0] right_len,
    input  logic                      suffix_in,
    output logic                      suffix_out,
    output logic                      moving,
    output logic                      hit,
    output logic [jts_pkg::ID_W-1:0]  id,
    output logic [jts_pkg::LEN_W-1:0] len,
    output logic [jts_pkg::ID_W-1:0]  id_next
);

    localparam logic [jts_pkg::CNT_W-1:0] IDX_C = jts_pkg::CNT_W'(INDEX);
    localparam logic [jts_pkg::POS_W-1:0] IDX_P = jts_pkg::POS_W'(INDEX);

    logic [jts_pkg::ID_W-1:0]  id_reg;
    logic [jts_pkg::LEN_W-1:0] len_reg;
    logic [jts_pkg::LEN_W-1:0] len_next;
    logic                      valid;
    logic                      longer;

    // A valid slot whose job is longer than the new one, with every valid slot to
    // its right longer too, moves right on a shortest-job insert
    assign valid      = IDX_C < ctrl.count;
    assign longer     = valid && (len_reg > ctrl.new_len);
    assign suffix_out = suffix_in && (longer || !valid);
    assign moving     = ctrl.sjf && valid && suffix_out;
    assign hit        = moving && (IDX_P == ctrl.run);

    always_comb
    begin
        id_next  = id_reg;
        len_next = len_reg;
        unique case (ctrl.op)
            jts_pkg::CELL_INSERT:
            begin
                if (left_moving)
                begin
                    id_next  = left_id;
                    len_next = left_len;
                end
                else if (moving || (IDX_C == ctrl.count))
                begin
                    id_next  = ctrl.new_id;
                    len_next = ctrl.new_len;
                end
            end
            jts_pkg::CELL_REMOVE:
            begin
                if (IDX_P >= ctrl.run)
                begin
                    id_next  = right_id;
                    len_next = right_len;
                end
            end
            default:
            begin
                id_next  = id_reg;
                len_next = len_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        len_reg <= len_next;
    end

    assign id  = id_reg;
    assign len = len_reg;

endmodule
